// File: rtl/core/sorted_list_table_defines.svh
// Assertion macros shared by the sorted list table RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef SORTED_LIST_TABLE_DEFINES_SVH
`define SORTED_LIST_TABLE_DEFINES_SVH

// Same-cycle implication, held off during reset
`define SLT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, held off during reset
`define SLT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/slt_pkg.sv
// Package for the sorted list table: sizes, mode and status codes, beat types.
// Depends on nothing; used by slt_cell, sorted_list_table and the testbench.
package slt_pkg;

   localparam int DEPTH = 32;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // Request mode codes
   localparam logic [1:0] MODE_INSERT    = 2'd0;
   localparam logic [1:0] MODE_DELETE    = 2'd1;
   localparam logic [1:0] MODE_DUMP_UP   = 2'd2;
   localparam logic [1:0] MODE_DUMP_DOWN = 2'd3;

   // Response status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_EMPTY     = 2'd3;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] data;
      logic               last;
      logic [1:0]         status;
   } rsp_type;

   // Command broadcast to every cell of the row
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_ROT_UP,
      CELL_ROT_DOWN
   } cell_op_type;

   typedef struct packed {
      cell_op_type        op;
      logic signed [31:0] value;
   } cell_ctl_type;

   // Compare results each cell reports back
   typedef struct packed {
      logic ins_shift;
      logic del_sel;
      logic eq;
   } cell_flag_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_UPDATE,
      S_DUMP
   } state_type;

endpackage

// File: rtl/core/slt_cell.sv
// One cell of the sorted row: holds one entry, compares it to the broadcast
// value and takes its neighbor's entry on shifts. Depends on slt_pkg.
module slt_cell (
   input  logic                  clock,
   input  slt_pkg::cell_ctl_type ctl,
   input  logic                  occ,
   input  logic signed [31:0]    prev_entry,
   input  logic                  prev_ins_shift,
   input  logic signed [31:0]    next_entry,
   output logic signed [31:0]    entry,
   output slt_pkg::cell_flag_type flags
);
   import slt_pkg::*;

   logic signed [31:0] entry_ff;
   logic signed [31:0] entry_in;
   logic               ins_shift;
   logic               del_sel;
   logic               eq;

   // Compare own entry against the broadcast value; empty cells count as larger
   assign ins_shift = !occ || (entry_ff > ctl.value);
   assign del_sel   = !occ || (entry_ff >= ctl.value);
   assign eq        = occ && (entry_ff == ctl.value);

   assign flags.ins_shift = ins_shift;
   assign flags.del_sel   = del_sel;
   assign flags.eq        = eq;
   assign entry           = entry_ff;

   // Select next entry: hold, open a gap, close a gap or rotate
   always_comb begin
      entry_in = entry_ff;
      case (ctl.op)
         CELL_INSERT: begin
            if (ins_shift) begin
               entry_in = prev_ins_shift ? prev_entry : ctl.value;
            end
         end
         CELL_DELETE: begin
            if (del_sel) begin
               entry_in = next_entry;
            end
         end
         CELL_ROT_UP:   entry_in = next_entry;
         CELL_ROT_DOWN: entry_in = prev_entry;
         default:       entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// File: rtl/core/sorted_list_table.sv
// Channel | Dir | Ports                           | Beat
// req     | in  | req_valid req_ready req_payload | mode, value
// rsp     | out | rsp_valid rsp_ready rsp_payload | data, last, status
//
// Insert and delete are accepted in idle; then, in the update state, every
// cell of the row compares and shifts at once.
// A dump of N entries sends one beat per cycle while rsp is not stalled,
// the row rotating one place per beat so it is back in order at the end.
// Reset clears the state, the entry count and rsp valid; cell contents need no clearing.
// A stalled rsp beat holds the block; no new req is taken until the item ends.
`include "sorted_list_table_defines.svh"

module sorted_list_table (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  slt_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output slt_pkg::rsp_type rsp_payload
);
   import slt_pkg::*;

   state_type          state_ff;
   state_type          state_in;
   req_type            op_ff;
   req_type            op_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic [CNT_W-1:0]   idx_ff;
   logic [CNT_W-1:0]   idx_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;

   cell_ctl_type       cell_ctl;
   logic signed [31:0] entries  [DEPTH];
   cell_flag_type      flags    [DEPTH];
   logic signed [31:0] prev_arr [DEPTH];
   logic signed [31:0] next_arr [DEPTH];
   logic               prev_shift [DEPTH];
   logic               occ      [DEPTH];
   logic [IDX_W-1:0]   tail_idx;
   logic signed [31:0] tail_value;
   logic               found;
   logic               out_free;
   logic               dump_last;

   // Locate the last occupied cell
   assign tail_idx   = IDX_W'(count_ff - CNT_W'(1));
   assign tail_value = entries[tail_idx];

   // Wire up the row; the ends wrap around for rotation
   for (genvar i = 0; i < DEPTH; i++) begin : g_row
      assign occ[i] = (count_ff > CNT_W'(i));
      if (i == 0) begin : g_head
         assign prev_arr[i]   = tail_value;
         assign prev_shift[i] = 1'b0;
      end else begin : g_body
         assign prev_arr[i]   = entries[i-1];
         assign prev_shift[i] = flags[i-1].ins_shift;
      end
      if (i == DEPTH - 1) begin : g_end
         assign next_arr[i] = entries[0];
      end else begin : g_mid
         assign next_arr[i] = (tail_idx == IDX_W'(i)) ? entries[0] : entries[i+1];
      end

      slt_cell u_cell (
         .clock          (clock),
         .ctl            (cell_ctl),
         .occ            (occ[i]),
         .prev_entry     (prev_arr[i]),
         .prev_ins_shift (prev_shift[i]),
         .next_entry     (next_arr[i]),
         .entry          (entries[i]),
         .flags          (flags[i])
      );
   end

   // Collect match flags from the row
   always_comb begin
      found = 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
         found = found | flags[i].eq;
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign dump_last = (idx_ff == count_ff - CNT_W'(1));

   // Next state, row command and response beat
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      cell_ctl.op   = CELL_HOLD;
      cell_ctl.value = op_ff.value;
      req_ready     = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in  = req_payload;
               idx_in = '0;
               if (req_payload.mode == MODE_INSERT || req_payload.mode == MODE_DELETE) begin
                  state_in = S_UPDATE;
               end else begin
                  state_in = S_DUMP;
               end
            end
         end
         S_UPDATE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in.data  = '0;
               rsp_in.last  = 1'b1;
               state_in     = S_IDLE;
               if (op_ff.mode == MODE_INSERT) begin
                  if (count_ff == CNT_W'(DEPTH)) begin
                     rsp_in.status = ST_FULL;
                  end else begin
                     cell_ctl.op   = CELL_INSERT;
                     count_in      = count_ff + CNT_W'(1);
                     rsp_in.status = ST_OK;
                  end
               end else begin
                  if (found) begin
                     cell_ctl.op   = CELL_DELETE;
                     count_in      = count_ff - CNT_W'(1);
                     rsp_in.status = ST_OK;
                  end else begin
                     rsp_in.status = ST_NOT_FOUND;
                  end
               end
            end
         end
         S_DUMP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (count_ff == '0) begin
                  rsp_in.data   = '0;
                  rsp_in.last   = 1'b1;
                  rsp_in.status = ST_EMPTY;
                  state_in      = S_IDLE;
               end else begin
                  rsp_in.last   = dump_last;
                  rsp_in.status = ST_OK;
                  idx_in        = idx_ff + CNT_W'(1);
                  if (op_ff.mode == MODE_DUMP_UP) begin
                     rsp_in.data = entries[0];
                     cell_ctl.op = CELL_ROT_UP;
                  end else begin
                     rsp_in.data = tail_value;
                     cell_ctl.op = CELL_ROT_DOWN;
                  end
                  if (dump_last) begin
                     state_in = S_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      idx_ff <= idx_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `SLT_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH), "entry count above depth")
   `SLT_ASSERT_NEXT(a_count_step, clock, reset, state_ff == S_UPDATE, (count_ff == $past(count_ff)) || (count_ff == $past(count_ff) + CNT_W'(1)) || (count_ff == $past(count_ff) - CNT_W'(1)), "entry count moved by more than one")
   `SLT_ASSERT_NEXT(a_dump_count_stable, clock, reset, state_ff == S_DUMP, $stable(count_ff), "entry count changed during dump")
   `SLT_ASSERT_SAME(a_full_status, clock, reset, rsp_valid_in && out_free && (state_ff == S_UPDATE) && (rsp_in.status == ST_FULL), count_ff == CNT_W'(DEPTH), "full status with room left")

endmodule

// File: bench/testbench.sv
// Self-checking bench for sorted_list_table: directed and random insert, delete and dump beats.
// Depends on slt_pkg for the beat types, mode and status codes, and the table depth.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import slt_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_ITEMS = 270;
   localparam int TAIL_CYCLES  = 20;

   logic    clock;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   // Shadow copy of the table, ascending, and the responses it predicts
   logic signed [31:0] stored_vals[$];
   rsp_type            expected_rsps[$];

   int fault_count  = 0;
   int stall_cycles = 0;
   int ready_hold   = 0;
   int mood_left    = 0;
   bit rx_calm      = 1'b0;
   bit tx_calm      = 1'b0;
   bit quiet_tail   = 1'b0;

   sorted_list_table i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic void note_fault(string msg);
      fault_count++;
      if (fault_count <= 10) begin
         $display("%0t: %s", $realtime, msg);
      end
   endfunction

   // Update the shadow table for one accepted request and queue its responses
   function automatic void predict_item(req_type beat);
      int                 pos;
      int                 n;
      rsp_type            rsp;
      logic signed [31:0] v;
      v   = beat.value;
      rsp = '0;
      rsp.last = 1'b1;
      case (beat.mode)
         MODE_INSERT: begin
            if (stored_vals.size() >= DEPTH) begin
               rsp.status = ST_FULL;
            end else begin
               // land after every equal value
               pos = 0;
               while (pos < stored_vals.size() && stored_vals[pos] <= v) pos++;
               stored_vals.insert(pos, v);
               rsp.status = ST_OK;
            end
            expected_rsps.push_back(rsp);
         end
         MODE_DELETE: begin
            pos = 0;
            while (pos < stored_vals.size() && stored_vals[pos] < v) pos++;
            if (pos >= stored_vals.size() || stored_vals[pos] != v) begin
               rsp.status = ST_NOT_FOUND;
            end else begin
               stored_vals.delete(pos);
               rsp.status = ST_OK;
            end
            expected_rsps.push_back(rsp);
         end
         default: begin
            n = stored_vals.size();
            if (n == 0) begin
               rsp.status = ST_EMPTY;
               expected_rsps.push_back(rsp);
            end else begin
               for (int i = 0; i < n; i++) begin
                  rsp.data   = stored_vals[(beat.mode == MODE_DUMP_UP) ? i : n - 1 - i];
                  rsp.last   = (i == n - 1);
                  rsp.status = ST_OK;
                  expected_rsps.push_back(rsp);
               end
            end
         end
      endcase
   endfunction

   // Present one request beat, hold it until accepted, then predict it.
   // Valid stays high on return; the next call or await_results settles it.
   task automatic send_beat(input logic [1:0] mode, input logic signed [31:0] value);
      req_type beat;
      beat.mode  = mode;
      beat.value = value;
      if (!tx_calm && !quiet_tail && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_payload <= beat;
      req_valid   <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_item(beat);
   endtask

   // Drop valid and wait until every predicted response has arrived
   task automatic await_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_rsps.size() != 0);
   endtask

   // Mostly small or already stored values so duplicates and hits are common
   function automatic logic signed [31:0] pick_value(bit for_delete);
      int roll;
      roll = $urandom_range(0, 9);
      if (for_delete && stored_vals.size() > 0 && roll < 6) begin
         return stored_vals[$urandom_range(0, stored_vals.size() - 1)];
      end
      if (roll < 5) return int'($urandom_range(0, 16)) - 8;
      if (roll == 5) begin
         case ($urandom_range(0, 3))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return 32'sh0;
            default: return -32'sd1;
         endcase
      end
      return $urandom();
   endfunction

   task automatic test_empty_table();
      send_beat(MODE_DUMP_UP, 32'sh0);
      send_beat(MODE_DUMP_DOWN, 32'sh7fff_ffff);
      send_beat(MODE_DELETE, 32'sh0);
   endtask

   task automatic test_extremes();
      send_beat(MODE_INSERT, 32'sh8000_0000);
      send_beat(MODE_INSERT, 32'sh7fff_ffff);
      send_beat(MODE_INSERT, 32'sh0);
      send_beat(MODE_INSERT, -32'sd1);
      send_beat(MODE_INSERT, 32'sh0);
      send_beat(MODE_INSERT, 32'sd1);
      send_beat(MODE_DUMP_UP, 32'sh8000_0000);
      send_beat(MODE_DUMP_DOWN, 32'sh0);
      send_beat(MODE_DELETE, 32'sh7fff_ffff);
      send_beat(MODE_DELETE, 32'sd5);
      send_beat(MODE_DELETE, 32'sh0);
      send_beat(MODE_DELETE, 32'sh8000_0000);
      send_beat(MODE_DELETE, -32'sd2);
      send_beat(MODE_DUMP_UP, -32'sd1);
   endtask

   // Fill to capacity, overflow, dump both ways, empty the table, then delete and dump it empty
   task automatic test_full_table();
      while (stored_vals.size() < DEPTH) send_beat(MODE_INSERT, pick_value(1'b0));
      send_beat(MODE_INSERT, 32'sh7fff_ffff);
      send_beat(MODE_INSERT, 32'sh8000_0000);
      send_beat(MODE_DUMP_DOWN, 32'sh0);
      send_beat(MODE_DUMP_UP, 32'sh0);
      await_results();
      while (stored_vals.size() > 0) begin
         send_beat(MODE_DELETE, stored_vals[$urandom_range(0, stored_vals.size() - 1)]);
      end
      send_beat(MODE_DELETE, pick_value(1'b0));
      send_beat(MODE_DUMP_DOWN, 32'sh0);
   endtask

   // Chunks that lean toward filling or draining; the last stretch runs without idling
   task automatic test_random_mix();
      int         left;
      int         roll;
      bit         grow;
      logic [1:0] mode;
      left = RANDOM_ITEMS;
      while (left > 0) begin
         grow    = $urandom_range(0, 1);
         tx_calm = ($urandom_range(0, 3) == 0);
         if (left <= 60) quiet_tail = 1'b1;
         for (int k = 0; k < 25 && left > 0; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 20) begin
               mode = $urandom_range(0, 1) ? MODE_DUMP_UP : MODE_DUMP_DOWN;
            end else if (roll < (grow ? 70 : 45)) begin
               mode = MODE_INSERT;
            end else begin
               mode = MODE_DELETE;
            end
            send_beat(mode, pick_value(mode == MODE_DELETE));
            left--;
         end
      end
   endtask

   // Receiver: stall in random bursts, with calm stretches and none at the tail
   always @(posedge clock) begin
      if (mood_left == 0) begin
         mood_left <= $urandom_range(40, 200);
         rx_calm   <= ($urandom_range(0, 2) == 0);
      end else begin
         mood_left <= mood_left - 1;
      end
      if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
         rsp_ready  <= 1'b0;
      end else if (!rx_calm && !quiet_tail && $urandom_range(0, 7) == 0) begin
         ready_hold <= $urandom_range(0, 17);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Compare each accepted response beat with the oldest prediction
   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            note_fault($sformatf("unexpected response: data %0d last %0b status %0d",
                                 rsp_payload.data, rsp_payload.last, rsp_payload.status));
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_payload.data !== want.data || rsp_payload.last !== want.last ||
                rsp_payload.status !== want.status) begin
               note_fault($sformatf(
                  "mismatch: data exp %0d got %0d, last exp %0b got %0b, status exp %0d got %0d",
                  want.data, rsp_payload.data, want.last, rsp_payload.last,
                  want.status, rsp_payload.status));
            end
         end
      end
   end

   // Watchdog: end the run if neither channel moves a beat for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_extremes();
      test_full_table();
      test_random_mix();
      await_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_rsps.size() != 0) begin
         note_fault($sformatf("%0d responses never arrived", expected_rsps.size()));
      end
      if (fault_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
